FILE: hdl/cbst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbst_pkg;

  // Width of one key and of one tree result.
  localparam int KEY_W = 32;

  // Default store depth of the block.
  localparam int MAX_KEYS_DEF = 64;

  typedef logic signed [KEY_W-1:0] key_t;

endpackage

`default_nettype wire

FILE: hdl/cbst_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one key per item, with the end-of-batch flag.
interface cbst_key_if
  import cbst_pkg::*;
();
  logic valid;
  logic ready;
  key_t key;
  logic last_key;

  modport source (output valid, output key, output last_key, input ready);
  modport sink (input valid, input key, input last_key, output ready);
endinterface

// Result channel: one tree position per item, in level order.
interface cbst_tree_if
  import cbst_pkg::*;
();
  logic valid;
  logic ready;
  key_t tree_key;
  logic last_out;
  logic overflow;

  modport source (output valid, output tree_key, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input tree_key, input last_out, input overflow,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/cbst_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port key memory: one write port, one read port with registered data.
module cbst_ram
  import cbst_pkg::*;
#(
  parameter int DEPTH = MAX_KEYS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire key_t          wdata,
  input  wire logic [AW-1:0] raddr,
  output key_t               rdata
);

  key_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered: data follows the address in the next cycle.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hdl/complete_bst_level_order_builder.sv
`timescale 1ns / 1ps
`default_nettype none

// Collects a batch of signed keys, one item per cycle, until the item flagged last_key.
// Keys beyond MAX_KEYS are dropped and the batch is marked with overflow. After the
// last key the block stops accepting, sorts the keys in place with an insertion sort
// (a shared compare unit against a one-write, one-read memory), walks the positions of
// the complete tree in order to lay the sorted keys out in array order, and then emits
// the tree in level order, one item per position, with last_out on the final one. The
// sort shifts key i once for each earlier key greater than it, so at most about n*n/2
// shifts in total; each result is held until it is taken before the next is read from
// the layout store. The sort loop over the key memory dominates for large batches.
module complete_bst_level_order_builder
  import cbst_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  cbst_key_if.sink    in_chan,
  cbst_tree_if.source out_chan
);

  localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int PW = CW + 1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SI_RD,
    ST_SI_CUR,
    ST_SJ_CMP,
    ST_SJ_PUT,
    ST_DESC,
    ST_PL_RD,
    ST_PL_WR,
    ST_ASC,
    ST_OUT_RD,
    ST_OUT_LD
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] count_r, count_nxt;
  logic          dropped_r, dropped_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] o_r, o_nxt;
  logic [CW-1:0] p_r, p_nxt;
  key_t          cur_r, cur_nxt;
  key_t          out_key_r, out_key_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          key_we;
  logic [AW-1:0] key_waddr;
  key_t          key_wdata;
  logic [AW-1:0] key_raddr;
  key_t          key_rd;

  logic          lay_we;
  logic [AW-1:0] lay_waddr;
  key_t          lay_wdata;
  logic [AW-1:0] lay_raddr;
  key_t          lay_rd;

  logic          in_acc;
  logic          out_acc;
  logic          has_room;
  logic [CW-1:0] n_new;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] i_dec;
  logic [CW-1:0] j_dec;
  logic [CW-1:0] j_dec2;
  logic [CW-1:0] k_inc;
  logic [CW-1:0] o_inc;
  logic [PW-1:0] left_pos;
  logic [PW-1:0] right_pos;
  logic [CW-1:0] parent_pos;
  logic [PW-1:0] n_wide;

  // Key store: arrival order, sorted in place.
  cbst_ram #(.DEPTH(MAX_KEYS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rd)
  );

  // Layout store: tree in array order.
  cbst_ram #(.DEPTH(MAX_KEYS)) u_lay_ram (
    .clk   (clk),
    .we    (lay_we),
    .waddr (lay_waddr),
    .wdata (lay_wdata),
    .raddr (lay_raddr),
    .rdata (lay_rd)
  );

  // Handshakes and port drive.
  assign in_chan.ready     = (state_r == ST_LOAD);
  assign in_acc            = in_chan.valid && (state_r == ST_LOAD);
  assign out_acc           = out_valid_r && out_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.tree_key = out_key_r;
  assign out_chan.last_out = out_last_r;
  assign out_chan.overflow = out_ovf_r;

  // Counter and tree position arithmetic.
  assign has_room   = (count_r < CW'(MAX_KEYS));
  assign n_new      = has_room ? count_r + CW'(1) : count_r;
  assign i_inc      = i_r + CW'(1);
  assign i_dec      = i_r - CW'(1);
  assign j_dec      = j_r - CW'(1);
  assign j_dec2     = j_r - CW'(2);
  assign k_inc      = k_r + CW'(1);
  assign o_inc      = o_r + CW'(1);
  assign left_pos   = {p_r, 1'b0} + PW'(1);
  assign right_pos  = {p_r, 1'b0} + PW'(2);
  assign parent_pos = (p_r - CW'(1)) >> 1;
  assign n_wide     = {1'b0, n_r};

  // Sequencer: load, sort, layout walk, output.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    o_nxt         = o_r;
    p_nxt         = p_r;
    cur_nxt       = cur_r;
    out_key_nxt   = out_key_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    out_valid_nxt = out_acc ? 1'b0 : out_valid_r;
    key_we        = 1'b0;
    key_waddr     = '0;
    key_wdata     = '0;
    key_raddr     = '0;
    lay_we        = 1'b0;
    lay_waddr     = '0;
    lay_wdata     = '0;
    lay_raddr     = '0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            key_we    = 1'b1;
            key_waddr = count_r[AW-1:0];
            key_wdata = in_chan.key;
            count_nxt = count_r + CW'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_chan.last_key) begin
            // Snapshot the batch and reopen the store for the next one.
            n_nxt       = n_new;
            ovf_nxt     = dropped_r || !has_room;
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            i_nxt       = CW'(1);
            k_nxt       = '0;
            o_nxt       = '0;
            p_nxt       = '0;
            state_nxt   = (n_new > CW'(1)) ? ST_SI_RD : ST_DESC;
          end
        end
      end

      ST_SI_RD: begin
        key_raddr = i_r[AW-1:0];
        state_nxt = ST_SI_CUR;
      end

      ST_SI_CUR: begin
        // Hold the key being inserted and fetch its left neighbor.
        cur_nxt   = key_rd;
        key_raddr = i_dec[AW-1:0];
        j_nxt     = i_r;
        state_nxt = ST_SJ_CMP;
      end

      ST_SJ_CMP: begin
        key_we    = 1'b1;
        key_waddr = j_r[AW-1:0];
        if (key_rd > cur_r) begin
          // Shift the larger key right and look one further left.
          key_wdata = key_rd;
          j_nxt     = j_dec;
          if (j_r == CW'(1)) begin
            state_nxt = ST_SJ_PUT;
          end else begin
            key_raddr = j_dec2[AW-1:0];
          end
        end else begin
          key_wdata = cur_r;
          i_nxt     = i_inc;
          state_nxt = (i_inc == n_r) ? ST_DESC : ST_SI_RD;
        end
      end

      ST_SJ_PUT: begin
        key_we    = 1'b1;
        key_waddr = '0;
        key_wdata = cur_r;
        i_nxt     = i_inc;
        state_nxt = (i_inc == n_r) ? ST_DESC : ST_SI_RD;
      end

      ST_DESC: begin
        // Go down left children to the leftmost position of the subtree.
        if (left_pos < n_wide) begin
          p_nxt = left_pos[CW-1:0];
        end else begin
          state_nxt = ST_PL_RD;
        end
      end

      ST_PL_RD: begin
        key_raddr = k_r[AW-1:0];
        state_nxt = ST_PL_WR;
      end

      ST_PL_WR: begin
        lay_we    = 1'b1;
        lay_waddr = p_r[AW-1:0];
        lay_wdata = key_rd;
        k_nxt     = k_inc;
        if (k_inc == n_r) begin
          state_nxt = ST_OUT_RD;
        end else if (right_pos < n_wide) begin
          p_nxt     = right_pos[CW-1:0];
          state_nxt = ST_DESC;
        end else begin
          state_nxt = ST_ASC;
        end
      end

      ST_ASC: begin
        // Climb while coming from a right child; stop after a left child.
        p_nxt = parent_pos;
        if (p_r[0]) begin
          state_nxt = ST_PL_RD;
        end
      end

      ST_OUT_RD: begin
        lay_raddr = o_r[AW-1:0];
        if (!out_valid_r) begin
          state_nxt = ST_OUT_LD;
        end
      end

      ST_OUT_LD: begin
        out_key_nxt   = lay_rd;
        out_last_nxt  = (o_inc == n_r);
        out_ovf_nxt   = ovf_r;
        out_valid_nxt = 1'b1;
        o_nxt         = o_inc;
        state_nxt     = (o_inc == n_r) ? ST_LOAD : ST_OUT_RD;
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
    n_r        <= n_nxt;
    ovf_r      <= ovf_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    o_r        <= o_nxt;
    p_r        <= p_nxt;
    cur_r      <= cur_nxt;
    out_key_r  <= out_key_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

`default_nettype wire
